FILE: hdl/date_add_days_unit_defines.svh
// Assertion helpers for the date adder, clocked on clk and held off during reset.
`ifndef DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Check a property on every rising edge of clk.
`define DADD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an expression is never true.
`define DADD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/dadd_pkg.sv
package dadd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ADD_W   = 15;
	localparam int ACC_W   = 16;
	localparam int R400_W  = 9;

	localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
	localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
	localparam logic [ACC_W-1:0]   CYCLE_400 = 16'd400;
	localparam logic [R400_W-1:0]  R400_LAST = 9'd399;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SUM,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic ge;
		logic eq;
		logic more_months;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic idle;
		logic load;
		logic mod_step;
		logic mod_done;
		logic sum_step;
		logic sum_add;
		logic walk_step;
		logic emit;
	} ctl_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/dadd_alu.sv
module dadd_alu (
	input  logic [dadd_pkg::ACC_W-1:0] a,
	input  logic [dadd_pkg::ACC_W-1:0] b,
	input  logic                       sub,
	output logic [dadd_pkg::ACC_W-1:0] res,
	output logic                       ge,
	output logic                       eq
);

	logic [dadd_pkg::ACC_W:0] diff;

	always_comb begin
		diff = {1'b0, a} - {1'b0, b};
		ge   = ~diff[dadd_pkg::ACC_W];
		eq   = (a == b);
		res  = sub ? diff[dadd_pkg::ACC_W-1:0] : (a + b);
	end

endmodule

FILE: hdl/dadd_ctrl.sv
module dadd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dadd_pkg::stat_t  stat,
	output dadd_pkg::ctl_t   ctl
);

	dadd_pkg::state_t state_q;
	dadd_pkg::state_t state_d;
	logic             gt;

	assign gt = stat.ge && !stat.eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dadd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dadd_pkg::ST_IDLE: begin
				if (in_valid) state_d = dadd_pkg::ST_MOD;
			end
			dadd_pkg::ST_MOD: begin
				if (!stat.ge) state_d = dadd_pkg::ST_SUM;
			end
			dadd_pkg::ST_SUM: begin
				if (!stat.more_months) state_d = dadd_pkg::ST_WALK;
			end
			dadd_pkg::ST_WALK: begin
				if (!gt && !stat.out_busy) state_d = dadd_pkg::ST_IDLE;
			end
			default: state_d = dadd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			dadd_pkg::ST_IDLE: begin
				ctl.idle = 1'b1;
				ctl.load = in_valid;
			end
			dadd_pkg::ST_MOD: begin
				ctl.mod_step = stat.ge;
				ctl.mod_done = !stat.ge;
			end
			dadd_pkg::ST_SUM: begin
				ctl.sum_step = stat.more_months;
				ctl.sum_add  = !stat.more_months;
			end
			dadd_pkg::ST_WALK: begin
				ctl.walk_step = gt;
				ctl.emit      = !gt && !stat.out_busy;
			end
			default: ctl = '0;
		endcase
	end

endmodule

FILE: hdl/date_add_days_unit.sv
// Adds a day count to a Gregorian date with one shared 16-bit add/subtract/compare unit.
// An item is taken only while the unit is idle. Each item then passes through these steps in
// order: the idle state takes the item, the year is reduced modulo 400 for the leap rule by
// repeated subtraction of 400, the month lengths ahead of the start day are summed and the
// count is added, the sum is walked down one month at a time, and the result is handed off,
// a hand-off that waits while the output is stalled.
// The result sits in an output register, so the next item
// may start while it waits to be taken; a second result holds in the walk until it is.
`include "date_add_days_unit_defines.svh"

module date_add_days_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dadd_pkg::YEAR_W-1:0]  start_year,
	input  logic [dadd_pkg::MONTH_W-1:0] start_month,
	input  logic [dadd_pkg::DAY_W-1:0]   start_day,
	input  logic [dadd_pkg::ADD_W-1:0]   days_to_add,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dadd_pkg::YEAR_W-1:0]  result_year,
	output logic [dadd_pkg::MONTH_W-1:0] result_month,
	output logic [dadd_pkg::DAY_W-1:0]   result_day
);

	dadd_pkg::ctl_t                ctl;
	dadd_pkg::stat_t               stat;
	logic [dadd_pkg::ACC_W-1:0]    acc_q;
	logic [dadd_pkg::YEAR_W-1:0]   year_q;
	logic [dadd_pkg::R400_W-1:0]   r400_q;
	logic [dadd_pkg::MONTH_W-1:0]  mon_q;
	logic [dadd_pkg::MONTH_W-1:0]  smon_q;
	logic [dadd_pkg::DAY_W-1:0]    sday_q;
	logic [dadd_pkg::ADD_W-1:0]    add_q;
	logic                          out_valid_q;
	logic [dadd_pkg::YEAR_W-1:0]   res_year_q;
	logic [dadd_pkg::MONTH_W-1:0]  res_month_q;
	logic [dadd_pkg::DAY_W-1:0]    res_day_q;
	logic                          leap;
	logic [dadd_pkg::DAY_W-1:0]    len;
	logic [dadd_pkg::ACC_W-1:0]    alu_b;
	logic [dadd_pkg::ACC_W-1:0]    alu_res;
	logic                          alu_sub;
	logic                          alu_ge;
	logic                          alu_eq;

	assign leap = (r400_q == '0) ||
		((year_q[1:0] == 2'b00) && (r400_q != 9'd100) && (r400_q != 9'd200) &&
		(r400_q != 9'd300));
	assign len = dadd_pkg::month_len(mon_q, leap);

	always_comb begin
		alu_sub = ctl.mod_step || ctl.walk_step || ctl.mod_done || ctl.emit;
		if (ctl.mod_step || ctl.mod_done) begin
			alu_b = dadd_pkg::CYCLE_400;
		end else if (ctl.sum_add) begin
			alu_b = {{(dadd_pkg::ACC_W-dadd_pkg::ADD_W){1'b0}}, add_q};
		end else begin
			alu_b = {{(dadd_pkg::ACC_W-dadd_pkg::DAY_W){1'b0}}, len};
		end
	end

	dadd_alu u_alu (
		.a   (acc_q),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.ge  (alu_ge),
		.eq  (alu_eq)
	);

	assign stat.ge          = alu_ge;
	assign stat.eq          = alu_eq;
	assign stat.more_months = (mon_q < smon_q) && (mon_q <= dadd_pkg::DECEMBER);
	assign stat.out_busy    = out_valid_q && out_stall;

	dadd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q  <= {{(dadd_pkg::ACC_W-dadd_pkg::YEAR_W){1'b0}}, start_year};
			year_q <= start_year;
			mon_q  <= dadd_pkg::JANUARY;
			smon_q <= start_month;
			sday_q <= start_day;
			add_q  <= days_to_add;
		end
		if (ctl.mod_step) begin
			acc_q <= alu_res;
		end
		if (ctl.mod_done) begin
			r400_q <= acc_q[dadd_pkg::R400_W-1:0];
			acc_q  <= {{(dadd_pkg::ACC_W-dadd_pkg::DAY_W){1'b0}}, sday_q};
		end
		if (ctl.sum_step) begin
			acc_q <= alu_res;
			mon_q <= mon_q + 4'd1;
		end
		if (ctl.sum_add) begin
			acc_q <= alu_res;
			mon_q <= dadd_pkg::JANUARY;
		end
		if (ctl.walk_step) begin
			acc_q <= alu_res;
			if (mon_q == dadd_pkg::DECEMBER) begin
				mon_q  <= dadd_pkg::JANUARY;
				year_q <= year_q + 14'd1;
				r400_q <= (r400_q == dadd_pkg::R400_LAST) ? '0 : r400_q + 9'd1;
			end else begin
				mon_q <= mon_q + 4'd1;
			end
		end
		if (ctl.emit) begin
			res_year_q  <= year_q;
			res_month_q <= mon_q;
			res_day_q   <= acc_q[dadd_pkg::DAY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall     = !ctl.idle;
	assign out_valid    = out_valid_q;
	assign result_year  = res_year_q;
	assign result_month = res_month_q;
	assign result_day   = res_day_q;

	`DADD_NEVER(a_emit_free, ctl.emit && out_valid_q && out_stall, "result overwritten while held")
	`DADD_ASSERT(a_rose_emit, $rose(out_valid_q) |-> $past(ctl.emit), "result without emit")
	`DADD_NEVER(a_walk_month, ctl.walk_step && (mon_q == '0 || mon_q > dadd_pkg::DECEMBER),
		"walk month out of range")
	`DADD_NEVER(a_r400_range, ctl.walk_step && r400_q > dadd_pkg::R400_LAST,
		"year residue out of range")

endmodule
